@@ design/npe_pkg.sv @@
// Shared types, constants and the gate evaluation function of the netlist partial evaluator.
package npe_pkg;

	localparam int WIRE_W     = 16;
	localparam int WIRE_COUNT = 1 << WIRE_W;
	localparam int CFG_W      = 17;
	localparam int TBL_W      = 4;
	localparam int QDEPTH     = 4;
	localparam int QPTR_W     = $clog2(QDEPTH);
	localparam int WSTORE_W   = 2;	// {known, value}

	typedef enum logic [0:0] {
		CMD_LOAD = 1'b0,
		CMD_GATE = 1'b1
	} cmd_t;

	typedef enum logic [0:0] {
		REG_INPUT_A_BITS      = 1'b0,
		REG_OUTPUT_WIRE_START = 1'b1
	} cfg_reg_t;

	// One classified operation, as it sits in the queue.
	typedef struct packed {
		logic              is_gate;
		logic              wr_en;     // load hits a wire
		logic [WIRE_W-1:0] wr_addr;   // load target or gate output wire
		logic              wr_val;
		logic [WIRE_W-1:0] left;
		logic [WIRE_W-1:0] right;
		logic [TBL_W-1:0]  tbl;
		logic              last;
		logic              internal;  // output wire below output_wire_start
	} op_t;

	typedef struct packed {
		logic valid;
		logic full;
	} q_stat_t;

	typedef struct packed {
		logic [TBL_W-1:0] tbl;
		logic             known;
		logic             value;
	} eval_t;

	// Left parent first, then right on the possibly rewritten table.
	function automatic eval_t gate_eval(input logic [TBL_W-1:0] tbl_in, input logic internal,
		input logic lk, input logic lv, input logic rk, input logic rv);
		logic [TBL_W-1:0] t;
		logic [1:0]       row;
		logic             c0;
		logic             c1;
		logic             ok;
		logic             oval;
		eval_t            res;
		t    = tbl_in;
		ok   = 1'b0;
		oval = 1'b0;
		if (lk && rk && internal) begin
			ok   = 1'b1;
			oval = t[{lv, rv}];
		end else begin
			if (lk) begin
				if ((t[{lv, 1'b0}] == t[{lv, 1'b1}]) && internal) begin
					ok   = 1'b1;
					oval = t[{lv, 1'b0}];
				end else begin
					row = lv ? t[3:2] : t[1:0];
					t   = {row, row};
				end
			end
			if (rk) begin
				c0 = t[{1'b0, rv}];
				c1 = t[{1'b1, rv}];
				if ((c0 == c1) && internal) begin
					ok   = 1'b1;
					oval = c0;
				end else begin
					t = {c1, c1, c0, c0};
				end
			end
		end
		res.tbl   = t;
		res.known = ok;
		res.value = ok & oval;
		return res;
	endfunction

endpackage

@@ design/npe_ram.sv @@
// Generic RAM: one write port, two registered read ports.
module npe_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

@@ design/npe_front.sv @@
// Front end: configuration registers, input handshake and item classification.
module npe_front
	import npe_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [0:0]        cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              item_valid,
	input  logic              cmd,
	input  logic [WIRE_W-1:0] a_position,
	input  logic              a_bit,
	input  logic [WIRE_W-1:0] left_wire,
	input  logic [WIRE_W-1:0] right_wire,
	input  logic [WIRE_W-1:0] out_wire,
	input  logic [TBL_W-1:0]  table_req,
	input  logic              is_last,
	input  logic              clearing,
	input  q_stat_t           q_stat,
	output logic              item_stall,
	output logic              push,
	output op_t               push_op
);

	logic [CFG_W-1:0] input_a_bits_q;
	logic [CFG_W-1:0] output_wire_start_q;
	logic [CFG_W-1:0] target;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			input_a_bits_q      <= '0;
			output_wire_start_q <= CFG_W'(WIRE_COUNT);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_INPUT_A_BITS:      input_a_bits_q      <= cfg_data;
				REG_OUTPUT_WIRE_START: output_wire_start_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign item_stall = clearing | q_stat.full;
	assign push       = item_valid & ~item_stall;

	// bit position counts from the top of the known input
	assign target = input_a_bits_q - CFG_W'(1) - {1'b0, a_position};

	always_comb begin
		push_op          = '0;
		push_op.is_gate  = (cmd == CMD_GATE);
		push_op.left     = left_wire;
		push_op.right    = right_wire;
		push_op.tbl      = table_req;
		push_op.last     = is_last;
		push_op.internal = ({1'b0, out_wire} < output_wire_start_q);
		push_op.wr_val   = a_bit;
		if (cmd == CMD_GATE) begin
			push_op.wr_addr = out_wire;
		end else begin
			push_op.wr_addr = target[WIRE_W-1:0];
			push_op.wr_en   = ({1'b0, a_position} < input_a_bits_q);
		end
	end

endmodule

@@ design/npe_queue.sv @@
// Short FIFO between front and back ends.
module npe_queue
	import npe_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  op_t     push_op,
	input  logic    pop,
	output op_t     head,
	output q_stat_t stat
);

	op_t               ent_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;

	assign head       = ent_q[rd_ptr_q];
	assign stat.valid = (cnt_q != '0);
	assign stat.full  = (cnt_q == (QPTR_W+1)'(QDEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + (QPTR_W+1)'(1);
				2'b01:   cnt_q <= cnt_q - (QPTR_W+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ design/npe_back.sv @@
// Back end: wire store, clearing pass, gate evaluation and result register.
module npe_back
	import npe_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  op_t              head,
	input  q_stat_t          q_stat,
	output logic             pop,
	output logic             clearing,
	input  logic             result_stall,
	output logic             result_valid,
	output logic [TBL_W-1:0] table_out,
	output logic             out_known,
	output logic             out_value,
	output logic             last_out
);

	logic [WIRE_W:0]        clr_q;
	logic                   s1_valid_q;
	op_t                    op_s1;
	logic                   fwd_valid_q;
	logic [WIRE_W-1:0]      fwd_addr_q;
	logic [WSTORE_W-1:0]    fwd_data_q;
	logic                   result_valid_q;
	logic [TBL_W-1:0]       table_q;
	logic                   known_q;
	logic                   value_q;
	logic                   last_q;

	logic [WSTORE_W-1:0]    rd_a;
	logic [WSTORE_W-1:0]    rd_b;
	logic [WSTORE_W-1:0]    left_d;
	logic [WSTORE_W-1:0]    right_d;
	eval_t                  ev;
	logic                   out_free;
	logic                   s1_adv;
	logic                   s1_take;
	logic                   op_wr;
	logic                   ram_we;
	logic [WIRE_W-1:0]      ram_waddr;
	logic [WSTORE_W-1:0]    ram_wdata;

	assign clearing = ~clr_q[WIRE_W];

	// one-deep bypass covers the write made at the edge the reads were taken
	assign left_d  = (fwd_valid_q && fwd_addr_q == op_s1.left)  ? fwd_data_q : rd_a;
	assign right_d = (fwd_valid_q && fwd_addr_q == op_s1.right) ? fwd_data_q : rd_b;

	assign ev = gate_eval(op_s1.tbl, op_s1.internal, left_d[1], left_d[0],
		right_d[1], right_d[0]);

	assign out_free = ~result_valid_q | ~result_stall;
	assign s1_adv   = s1_valid_q & (~op_s1.is_gate | out_free);
	assign s1_take  = ~s1_valid_q | s1_adv;
	assign pop      = q_stat.valid & s1_take & ~clearing;

	assign op_wr = s1_adv & (op_s1.is_gate ? ev.known : op_s1.wr_en);

	always_comb begin
		if (clearing) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q[WIRE_W-1:0];
			ram_wdata = '0;
		end else begin
			ram_we    = op_wr;
			ram_waddr = op_s1.wr_addr;
			ram_wdata = {1'b1, op_s1.is_gate ? ev.value : op_s1.wr_val};
		end
	end

	npe_ram #(
		.WIDTH (WSTORE_W),
		.DEPTH (WIRE_COUNT)
	) u_store (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.re      (pop),
		.raddr_a (head.left),
		.raddr_b (head.right),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q          <= '0;
			s1_valid_q     <= 1'b0;
			fwd_valid_q    <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (clearing) begin
				clr_q <= clr_q + (WIRE_W+1)'(1);
			end
			if (s1_take) begin
				s1_valid_q <= pop;
			end
			if (op_wr) begin
				fwd_valid_q <= 1'b1;
			end
			if (s1_adv && op_s1.is_gate) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			op_s1 <= head;
		end
		if (op_wr) begin
			fwd_addr_q <= ram_waddr;
			fwd_data_q <= ram_wdata;
		end
		if (s1_adv && op_s1.is_gate) begin
			table_q <= ev.tbl;
			known_q <= ev.known;
			value_q <= ev.value;
			last_q  <= op_s1.last;
		end
	end

	assign result_valid = result_valid_q;
	assign table_out    = table_q;
	assign out_known    = known_q;
	assign out_value    = value_q;
	assign last_out     = last_q;

endmodule

@@ design/netlist_partial_evaluator.sv @@
// Top level of the netlist partial evaluator.
//
//  channel  | handshake                 | transfer when
//  ---------+---------------------------+-------------------------------
//  item     | item_valid / item_stall   | item_valid & !item_stall
//  result   | result_valid / result_stall | result_valid & !result_stall
//  config   | cfg_we                    | every edge with cfg_we high
//
// One item per cycle sustained while result_stall is low; a gate's result
// passes through the queue, the store read and then the result register.
// The rate is set by the wire store: two reads and one write per cycle.
// After reset a clearing pass over all WIRE_COUNT (65536) wires zeroes the known
// flags; item_stall stays high for its length, config writes are taken.
// Outside the clearing pass item_stall rises only on a full queue;
// result_stall backs up through the evaluation stage into the queue.
module netlist_partial_evaluator
	import npe_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// configuration
	input  logic              cfg_we,
	input  logic [0:0]        cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	// items
	input  logic              item_valid,
	output logic              item_stall,
	input  logic              cmd,
	input  logic [WIRE_W-1:0] a_position,
	input  logic              a_bit,
	input  logic [WIRE_W-1:0] left_wire,
	input  logic [WIRE_W-1:0] right_wire,
	input  logic [WIRE_W-1:0] out_wire,
	input  logic [TBL_W-1:0]  table_req,
	input  logic              is_last,
	// results
	output logic              result_valid,
	input  logic              result_stall,
	output logic [TBL_W-1:0]  table_out,
	output logic              out_known,
	output logic              out_value,
	output logic              last_out
);

	logic    push;
	op_t     push_op;
	logic    pop;
	op_t     head;
	q_stat_t q_stat;
	logic    clearing;

	// front: config, handshake, load target and output-class decode
	npe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.item_valid (item_valid),
		.cmd        (cmd),
		.a_position (a_position),
		.a_bit      (a_bit),
		.left_wire  (left_wire),
		.right_wire (right_wire),
		.out_wire   (out_wire),
		.table_req  (table_req),
		.is_last    (is_last),
		.clearing   (clearing),
		.q_stat     (q_stat),
		.item_stall (item_stall),
		.push       (push),
		.push_op    (push_op)
	);

	// decouples the input handshake from result backpressure
	npe_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.pop     (pop),
		.head    (head),
		.stat    (q_stat)
	);

	// back: store lookups, bypass, table rewrite, store update, result register
	npe_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_stat       (q_stat),
		.pop          (pop),
		.clearing     (clearing),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.table_out    (table_out),
		.out_known    (out_known),
		.out_value    (out_value),
		.last_out     (last_out)
	);

endmodule

@@ design/npe_checker.sv @@
// Port-level checks on the netlist partial evaluator and their binding.
module npe_checker
	import npe_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_stall,
	input logic              cmd,
	input logic              result_valid,
	input logic              result_stall,
	input logic [TBL_W-1:0]  table_out,
	input logic              out_known,
	input logic              out_value,
	input logic              last_out
);

	logic [3:0] pending_q;
	logic       gate_in;
	logic       res_out;

	assign gate_in = item_valid & ~item_stall & (cmd == CMD_GATE);
	assign res_out = result_valid & ~result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 4'(gate_in) - 4'(res_out);
		end
	end

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid
			&& $stable(table_out) && $stable(out_known)
			&& $stable(out_value) && $stable(last_out))
		else $error("result changed while stalled");

	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !out_known |-> !out_value)
		else $error("out_value set without out_known");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> pending_q != 4'd0)
		else $error("result without an outstanding gate");

	a_clear_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> item_stall)
		else $error("item taken before clearing pass");

endmodule

bind netlist_partial_evaluator npe_checker u_npe_checker (.*);
